FILE: hw/rtl/mavg_pkg.sv
// Shared constants, types and state codes of the moving average filter.
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  localparam int RING_DEPTH    = 256;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;

  localparam int RING_AW   = $clog2(RING_DEPTH);
  localparam int WIN_W     = RING_AW + 1;
  localparam int SUM_W     = SAMPLE_BITS + RING_AW;
  localparam int SCALED_W  = SUM_W + FRACTION_BITS;
  localparam int AVG_W     = 24;
  localparam int DIV_STEPS = SCALED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [PADDR_W-3:0] REG_WINDOW   = 1'b0;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(4);

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic             restart;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mavg_if.sv
// Stream interfaces for input samples and output averages.
`timescale 1ns / 1ps
`default_nettype none

interface mavg_in_if
  import mavg_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface mavg_out_if
  import mavg_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mavg_cfg.sv
// APB register block holding the window size.
`timescale 1ns / 1ps
`default_nettype none

module mavg_cfg
  import mavg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [WIN_W-1:0] window_size;
  logic             sel_window;
  logic             wr_window;

  assign pready     = 1'b1;
  assign sel_window = (paddr[PADDR_W-1:2] == REG_WINDOW);
  assign wr_window  = psel && penable && pwrite && sel_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (wr_window) begin
      window_size <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = sel_window ? PDATA_W'(window_size) : '0;

  // Zero acts as a window of one; anything past the ring depth is clamped.
  always_comb begin
    if (window_size == '0) begin
      cfg.window = WIN_W'(1);
    end else if (window_size > WIN_W'(RING_DEPTH)) begin
      cfg.window = WIN_W'(RING_DEPTH);
    end else begin
      cfg.window = window_size;
    end
    cfg.restart = wr_window;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mavg_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend, truncation toward zero.
`timescale 1ns / 1ps
`default_nettype none

module mavg_div
  import mavg_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [SCALED_W-1:0] dividend,
  input  wire logic        [WIN_W-1:0]    divisor,
  output logic                            done,
  output logic signed      [AVG_W-1:0]    quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic                 neg;
  logic [SCALED_W-1:0]  quo;
  logic [WIN_W-1:0]     rem;
  logic [WIN_W-1:0]     dvs;
  logic [WIN_W:0]       rem_sh;
  logic                 fits;
  logic [SCALED_W-1:0]  quo_signed;

  assign rem_sh = {rem, quo[SCALED_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SCALED_W-1];
      quo <= dividend[SCALED_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SCALED_W-2:0], fits};
      rem <= fits ? WIN_W'(rem_sh - {1'b0, dvs}) : rem_sh[WIN_W-1:0];
    end
  end

  // The magnitude quotient takes the sign of the dividend.
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[AVG_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/moving_average_filter_unit.sv
// Boxcar moving average: sample ring in RAM, running sum, iterative divide.
// A sample that completes a window is registered, updates the running sum, then runs
// the 32-step divide by the window size before its average is registered out.
// Only one sample is in work at a time; intake waits while the output stalls.
// Reset: synchronous; clears the sequence, ring pointer and window size (to 4).
// The ring RAM is not cleared; an entry's read data is only used after it was written.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter_unit
  import mavg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  mavg_in_if.sink                 in_ch,
  mavg_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t   cfg;
  state_t state, state_next;

  logic [RING_AW-1:0]            write_slot;
  logic [WIN_W-1:0]              fill_count;
  logic signed [SUM_W-1:0]       running_sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic                          accept;
  logic [RING_AW-1:0]            old_slot;
  logic [SAMPLE_BITS-1:0]        ring_rdata;
  logic                          full_before;
  logic                          full_after;
  logic [WIN_W-1:0]              fill_new;
  logic signed [SUM_W-1:0]       leaving;
  logic signed [SUM_W-1:0]       sum_new;
  logic signed [SCALED_W-1:0]    dividend;
  logic                          div_start;
  logic                          div_done;
  logic signed [AVG_W-1:0]       quotient;
  logic                          out_free;
  logic                          out_load;

  mavg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The leaving sample is read at accept, in ST_IDLE, and the new one written in ST_UPDATE,
  // so read and write never meet in the same cycle.
  assign old_slot = write_slot - cfg.window[RING_AW-1:0];

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (write_slot),
    .wdata (sample_q),
    .re    (accept),
    .raddr (old_slot),
    .rdata (ring_rdata)
  );

  assign full_before = (fill_count >= cfg.window);
  assign fill_new    = full_before ? fill_count : fill_count + 1'b1;
  assign full_after  = (fill_new >= cfg.window);
  assign leaving     = full_before ? SUM_W'(signed'(ring_rdata)) : '0;
  assign sum_new     = running_sum - leaving + SUM_W'(sample_q);
  assign dividend    = SCALED_W'(sum_new) <<< FRACTION_BITS;

  mavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cfg.window),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (full_after) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
    end else if (cfg.restart) begin
      fill_count  <= '0;
      running_sum <= '0;
    end else if (accept && in_ch.start_req) begin
      fill_count  <= '0;
      running_sum <= '0;
    end else if (state == ST_UPDATE) begin
      write_slot  <= write_slot + 1'b1;
      fill_count  <= fill_new;
      running_sum <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= in_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.average <= quotient;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mavg_checker.sv
// Port-level assertions for the moving average filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mavg_checker
  import mavg_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [AVG_W-1:0] average
);

  // One sample is worked on at a time, so intake closes right after a transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is still in work");

  // An average never appears in the cycle right after a sample transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("average appeared too soon after a sample");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average))
    else $error("stalled average changed or dropped");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind moving_average_filter_unit mavg_checker u_mavg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .average   (out_ch.average)
);

`default_nettype wire
